[rtl/core/nearest_palette_l1_mean_distance_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check macros used by the nearest palette distance back end.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_L1_MEAN_DISTANCE_ASSERT_SVH
`define NEAREST_PALETTE_L1_MEAN_DISTANCE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define NPL1_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("npl1: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define NPL1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("npl1: next-cycle check failed");
`else
`define NPL1_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define NPL1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/npl1_pkg.sv]
// ----------------------------------------------------------------------------
// npl1_pkg
// Shared constants, types and helpers of the nearest palette distance block.
// ----------------------------------------------------------------------------
package npl1_pkg;

	localparam int NUM_CENTERS = 8;
	localparam int MAX_SAMPLES = 1023;

	localparam int NUM_REGS = 8;
	localparam int CH_W     = 12;
	localparam int CTR_W    = 3 * CH_W;
	localparam int PIX_W    = 8;
	localparam int DIST_W   = 14;
	localparam int SUM_W    = 24;
	localparam int CNT_W    = 10;
	localparam int IDX_W    = $clog2(NUM_REGS);

	localparam int APB_DW = 64;
	localparam int APB_AW = $clog2(NUM_REGS * 8);

	localparam int SCAN_CNT = (NUM_CENTERS > NUM_REGS) ? NUM_REGS :
		((NUM_CENTERS < 1) ? 1 : NUM_CENTERS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_CNT - 1);

	localparam int COUNT_CAP = (1 << CNT_W) - 1;
	localparam int LIMIT_I = (MAX_SAMPLES > COUNT_CAP) ? COUNT_CAP :
		((MAX_SAMPLES < 1) ? 1 : MAX_SAMPLES);
	localparam logic [CNT_W-1:0] SAMPLE_LIMIT = CNT_W'(LIMIT_I);

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	localparam int FIFO_DEPTH = 2;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	typedef logic [CTR_W-1:0] center_t;
	typedef center_t [NUM_REGS-1:0] center_arr_t;

	// Work handed from the front to the back.
	typedef struct packed {
		logic [DIST_W-1:0] min_dist;
		logic              start;
	} job_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_SCAN,
		FR_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

	function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

[rtl/core/nearest_palette_l1_mean_distance.sv]
// ----------------------------------------------------------------------------
// nearest_palette_l1_mean_distance
// Nearest palette centre by L1 distance with a running mean of the minima.
// ----------------------------------------------------------------------------
// Usage:
//   Write the eight 36-bit palette centres (three 8.4 channels, channel 0 in
//   bits 11:0) over the APB port at byte address 8*i while the block is idle.
//   Push a pixel (chan0..chan2, start_req) when full is low; start_req clears
//   the running sum and count before this pixel is counted.
//   Each pixel gives one result transaction: min_dist, mean_dist
//   (floor of sum/count), sample_count and full_res. Pop it while empty is low.
// Timing:
//   The front scans one centre per cycle and takes the next pixel once its
//   job is queued. The back divides by restoring, one quotient bit per cycle,
//   and takes the next job only after the result of the last one is loaded
//   into the output register.
// Reset and stall:
//   Reset clears the centres, sum, count and all queues. A stalled receiver
//   fills the output register, then the job queue, then the front, which
//   then raises full; no transaction is dropped.
// ----------------------------------------------------------------------------
module nearest_palette_l1_mean_distance (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [npl1_pkg::APB_AW-1:0]       paddr,
	input  logic [npl1_pkg::APB_DW-1:0]       pwdata,
	output logic [npl1_pkg::APB_DW-1:0]       prdata,
	output logic                              pready,
	// pixel input
	input  logic                              push,
	output logic                              full,
	input  logic [npl1_pkg::PIX_W-1:0]        chan0,
	input  logic [npl1_pkg::PIX_W-1:0]        chan1,
	input  logic [npl1_pkg::PIX_W-1:0]        chan2,
	input  logic                              start_req,
	// results
	output logic                              empty,
	input  logic                              pop,
	output logic [npl1_pkg::DIST_W-1:0]       min_dist,
	output logic [npl1_pkg::DIST_W-1:0]       mean_dist,
	output logic [npl1_pkg::CNT_W-1:0]        sample_count,
	output logic                              full_res
);
	import npl1_pkg::*;

	center_arr_t       centers_q;
	logic [IDX_W-1:0]  reg_idx;
	logic              cfg_wr;

	job_t              fr_job, bk_job;
	logic              fr_push, q_full, q_pop, q_empty;

	// Register file: one 36-bit centre per 8-byte slot, always ready
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:3];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = APB_DW'(centers_q[reg_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centers_q <= '0;
		end else if (cfg_wr) begin
			// keep the low 36 bits, drop the rest of the data word
			centers_q[reg_idx] <= pwdata[CTR_W-1:0];
		end
	end

	// Front: take pixels and find the nearest centre
	npl1_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.chan0     (chan0),
		.chan1     (chan1),
		.chan2     (chan2),
		.start_req (start_req),
		.centers   (centers_q),
		.job       (fr_job),
		.job_push  (fr_push),
		.job_full  (q_full)
	);

	// Decouple the scan from the divider
	npl1_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.wr_job (fr_job),
		.full   (q_full),
		.pop    (q_pop),
		.rd_job (bk_job),
		.empty  (q_empty)
	);

	// Back: accumulate, divide and present the result
	npl1_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (bk_job),
		.job_empty    (q_empty),
		.job_pop      (q_pop),
		.min_dist     (min_dist),
		.mean_dist    (mean_dist),
		.sample_count (sample_count),
		.full_res     (full_res),
		.empty        (empty),
		.pop          (pop)
	);

endmodule

[rtl/core/npl1_front.sv]
// ----------------------------------------------------------------------------
// npl1_front
// Accepts pixels and scans the palette, one centre per cycle, for the
// smallest L1 distance.
// ----------------------------------------------------------------------------
module npl1_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [npl1_pkg::PIX_W-1:0]        chan0,
	input  logic [npl1_pkg::PIX_W-1:0]        chan1,
	input  logic [npl1_pkg::PIX_W-1:0]        chan2,
	input  logic                              start_req,
	input  npl1_pkg::center_arr_t             centers,
	output npl1_pkg::job_t                    job,
	output logic                              job_push,
	input  logic                              job_full
);
	import npl1_pkg::*;

	front_state_t         state_q, state_d;
	logic [CH_W-1:0]      px0_q, px1_q, px2_q;
	logic                 start_q;
	logic [IDX_W-1:0]     idx_q;
	logic [DIST_W-1:0]    best_q;
	logic [DIST_W-1:0]    cand_dist;
	center_t              ctr;
	logic                 accept;

	assign accept = push && !full;
	assign ctr    = centers[idx_q];

	// L1 distance from the held pixel to the centre under the scan index
	assign cand_dist = DIST_W'(abs_diff(px0_q, ctr[CH_W-1:0]))
		+ DIST_W'(abs_diff(px1_q, ctr[2*CH_W-1:CH_W]))
		+ DIST_W'(abs_diff(px2_q, ctr[3*CH_W-1:2*CH_W]));

	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE: begin
				if (push) state_d = FR_SCAN;
			end
			FR_SCAN: begin
				if (idx_q == LAST_IDX) state_d = FR_PUSH;
			end
			FR_PUSH: begin
				if (!job_full) state_d = FR_IDLE;
			end
			default: state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		full     = 1'b1;
		job_push = 1'b0;
		case (state_q)
			FR_IDLE: full = 1'b0;
			FR_PUSH: job_push = !job_full;
			default: ;
		endcase
	end

	assign job.min_dist = best_q;
	assign job.start    = start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Widen the bytes to 8.4 on capture, then fold in one centre a cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			px0_q   <= {chan0, 4'b0000};
			px1_q   <= {chan1, 4'b0000};
			px2_q   <= {chan2, 4'b0000};
			start_q <= start_req;
			idx_q   <= '0;
			best_q  <= '1;
		end else if (state_q == FR_SCAN) begin
			if (cand_dist < best_q) best_q <= cand_dist;
			idx_q <= idx_q + IDX_W'(1);
		end
	end

endmodule

[rtl/core/npl1_fifo.sv]
// ----------------------------------------------------------------------------
// npl1_fifo
// Short job queue between the distance scan and the accumulator.
// ----------------------------------------------------------------------------
module npl1_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  npl1_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output npl1_pkg::job_t rd_job,
	output logic           empty
);
	import npl1_pkg::*;

	job_t              mem_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FCNT_W-1:0] cnt_q;
	logic              do_wr, do_rd;

	assign full   = (cnt_q == FCNT_W'(FIFO_DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_wr  = push && !full;
	assign do_rd  = pop && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + FPTR_W'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + FPTR_W'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + FCNT_W'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - FCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

[rtl/core/npl1_back.sv]
// ----------------------------------------------------------------------------
// npl1_back
// Accumulates distances, divides sum by count one quotient bit a cycle and
// holds the result in an output register.
// ----------------------------------------------------------------------------
`include "nearest_palette_l1_mean_distance_assert.svh"

module npl1_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  npl1_pkg::job_t                job,
	input  logic                          job_empty,
	output logic                          job_pop,
	output logic [npl1_pkg::DIST_W-1:0]   min_dist,
	output logic [npl1_pkg::DIST_W-1:0]   mean_dist,
	output logic [npl1_pkg::CNT_W-1:0]    sample_count,
	output logic                          full_res,
	output logic                          empty,
	input  logic                          pop
);
	import npl1_pkg::*;

	back_state_t         state_q, state_d;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    count_q;
	logic [DIST_W-1:0]   min_q;
	logic                full_q;
	logic [SUM_W-1:0]    dvd_q;
	logic [SUM_W-1:0]    quo_q;
	logic [CNT_W-1:0]    rem_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;

	logic                take;
	logic                out_load;
	logic [SUM_W-1:0]    base_sum;
	logic [CNT_W-1:0]    base_cnt;
	logic [SUM_W:0]      sum_ext;
	logic [CNT_W:0]      trial;
	logic                qbit;

	assign take     = job_pop && !job_empty;
	assign base_sum = job.start ? '0 : sum_q;
	assign base_cnt = job.start ? '0 : count_q;
	assign sum_ext  = {1'b0, base_sum} + (SUM_W + 1)'(job.min_dist);

	// Restoring division step
	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign qbit  = (trial >= {1'b0, count_q});

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!job_empty) state_d = BK_DIV;
			end
			BK_DIV: begin
				if (step_q == LAST_STEP) state_d = BK_DONE;
			end
			BK_DONE: begin
				if (!out_valid_q || pop) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BK_IDLE: job_pop = 1'b1;
			BK_DONE: out_load = !out_valid_q || pop;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				if (base_cnt >= SAMPLE_LIMIT) begin
					sum_q   <= base_sum;
					count_q <= base_cnt;
				end else begin
					sum_q   <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
					count_q <= base_cnt + CNT_W'(1);
				end
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			min_q  <= job.min_dist;
			full_q <= (base_cnt >= SAMPLE_LIMIT);
			dvd_q  <= (base_cnt >= SAMPLE_LIMIT) ? base_sum :
				(sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0]);
			rem_q  <= '0;
			quo_q  <= '0;
			step_q <= '0;
		end else if (state_q == BK_DIV) begin
			rem_q  <= qbit ? CNT_W'(trial - {1'b0, count_q}) : trial[CNT_W-1:0];
			quo_q  <= {quo_q[SUM_W-2:0], qbit};
			dvd_q  <= {dvd_q[SUM_W-2:0], 1'b0};
			step_q <= step_q + STEP_W'(1);
		end
		if (out_load) begin
			min_dist     <= min_q;
			mean_dist    <= (count_q == '0) ? '0 : quo_q[DIST_W-1:0];
			sample_count <= count_q;
			full_res     <= full_q;
		end
	end

	assign empty = !out_valid_q;

	// Count never passes the sample limit
	`NPL1_ASSERT_NOW(a_count_limit, clk, arst_n, 1'b1, count_q <= SAMPLE_LIMIT)
	// A waiting result is replaced only when it is taken in the same cycle
	`NPL1_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_load && out_valid_q, pop)
	// A taken job always starts the divider
	`NPL1_ASSERT_NEXT(a_take_divides, clk, arst_n, take, state_q == BK_DIV && step_q == '0)
	// The divider never runs past its last step
	`NPL1_ASSERT_NOW(a_step_bound, clk, arst_n, state_q == BK_DIV, step_q <= LAST_STEP)

endmodule
